// File: sv/pinhole_ray_direction_unit_defines.svh
// Assertion macros for the pinhole ray direction unit.
// Used at the end of the top level; expects clk_i and rst_ni in scope.
`ifndef PINHOLE_RAY_DIRECTION_UNIT_DEFINES_SVH
`define PINHOLE_RAY_DIRECTION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/prd_pkg.sv
// Package of the pinhole ray direction unit: widths, stage counts,
// register codes, payload structs and the component unpack function.
// No dependencies.
`default_nettype none

package prd_pkg;

  localparam int CompWidth = 21;
  localparam int RegWidth  = 63;
  localparam int WinWidth  = 17;
  localparam int WinOne    = 65536;
  localparam int ScrWidth  = 16;
  localparam int PxWidth   = 34;
  localparam int ProdWidth = PxWidth + CompWidth;
  localparam int DWidth    = 56;
  localparam int MagWidth  = DWidth - 1;
  localparam int NormBits  = 30;
  localparam int SqWidth   = 2 * NormBits;
  localparam int LenWidth  = SqWidth + 2;
  localparam int RootWidth = LenWidth / 2;
  localparam int RemWidth  = RootWidth + 3;
  localparam int QWidth    = 16;
  localparam int NumWidth  = NormBits + QWidth + 1;
  localparam int DenWidth  = RootWidth + 1;
  localparam int OutWidth  = 16;

  localparam int GeomStg  = 3;
  localparam int NormStg  = 4;
  localparam int SqrtStg  = RootWidth;
  localparam int DivStg   = QWidth + 2;
  localparam int GeomBase = 0;
  localparam int NormBase = GeomBase + GeomStg;
  localparam int SqrtBase = NormBase + NormStg;
  localparam int DivBase  = SqrtBase + SqrtStg;
  localparam int NumStg   = DivBase + DivStg;

  typedef enum logic [2:0] {
    RegCorner = 3'd0,
    RegAxisU  = 3'd1,
    RegAxisV  = 3'd2,
    RegWinSx  = 3'd3,
    RegWinSy  = 3'd4,
    RegWinEx  = 3'd5,
    RegWinEy  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [RegWidth-1:0] corner;
    logic [RegWidth-1:0] axis_u;
    logic [RegWidth-1:0] axis_v;
    logic [WinWidth-1:0] win_sx;
    logic [WinWidth-1:0] win_sy;
    logic [WinWidth-1:0] win_ex;
    logic [WinWidth-1:0] win_ey;
  } cfg_t;

  typedef struct packed {
    logic [2:0][MagWidth-1:0] mag;
    logic [2:0]               neg;
  } geom_t;

  typedef struct packed {
    logic [2:0][NormBits-1:0] e;
    logic [2:0]               neg;
    logic                     zero;
    logic [LenWidth-1:0]      len2;
  } norm_t;

  typedef struct packed {
    logic [2:0][NormBits-1:0] e;
    logic [2:0]               neg;
    logic                     zero;
  } side_t;

  typedef struct packed {
    side_t                side;
    logic [RootWidth-1:0] r;
  } root_t;

  function automatic logic signed [CompWidth-1:0] comp(input logic [RegWidth-1:0] v,
                                                       input int unsigned i);
    return v[i*CompWidth +: CompWidth];
  endfunction

endpackage

`default_nettype wire

// File: sv/pinhole_ray_direction_unit.sv
// Top level of the pinhole ray direction unit: configuration registers,
// stage valid and enable chain, and the four pipeline sections.
// Depends on prd_pkg, prd_geom, prd_norm, prd_sqrt, prd_div and the defines header.
//
//   channel   direction  contents
//   s_axis    in         tdata: screen_x, screen_y
//   m_axis    out        tdata: dir_x, dir_y, dir_z; tuser: degenerate
//   cfg       in         write enable, register index, 63-bit data
//
// One item enters per cycle while s_axis_tready is high; a stalled output can hold it low.
// Most of the pipeline depth comes from the one-bit-per-stage square root and divider.
// Each stage holds its item when the next stage cannot take it, so bubbles close up.
// Reset clears the stage valid bits and loads the register reset values.
`default_nettype none
`include "pinhole_ray_direction_unit_defines.svh"

module pinhole_ray_direction_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [62:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // screen_x [15:0], screen_y [31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  output logic [0:0]       m_axis_tuser    // degenerate [0]
);

  localparam int N = prd_pkg::NumStg;

  prd_pkg::cfg_t  cfg_q;
  logic [N-1:0]   valid_q;
  logic [N-1:0]   en;
  prd_pkg::geom_t geom;
  prd_pkg::norm_t norm;
  prd_pkg::root_t root;
  logic           degen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.corner <= '0;
      cfg_q.axis_u <= '0;
      cfg_q.axis_v <= '0;
      cfg_q.win_sx <= '0;
      cfg_q.win_sy <= '0;
      cfg_q.win_ex <= prd_pkg::WinWidth'(prd_pkg::WinOne);
      cfg_q.win_ey <= prd_pkg::WinWidth'(prd_pkg::WinOne);
    end else if (cfg_we_i) begin
      unique case (prd_pkg::reg_idx_e'(cfg_idx_i))
        prd_pkg::RegCorner: cfg_q.corner <= cfg_wdata_i;
        prd_pkg::RegAxisU:  cfg_q.axis_u <= cfg_wdata_i;
        prd_pkg::RegAxisV:  cfg_q.axis_v <= cfg_wdata_i;
        prd_pkg::RegWinSx:  cfg_q.win_sx <= cfg_wdata_i[prd_pkg::WinWidth-1:0];
        prd_pkg::RegWinSy:  cfg_q.win_sy <= cfg_wdata_i[prd_pkg::WinWidth-1:0];
        prd_pkg::RegWinEx:  cfg_q.win_ex <= cfg_wdata_i[prd_pkg::WinWidth-1:0];
        prd_pkg::RegWinEy:  cfg_q.win_ey <= cfg_wdata_i[prd_pkg::WinWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en[N-1] = !valid_q[N-1] || m_axis_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= s_axis_tvalid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  prd_geom u_geom (
    .clk_i (clk_i),
    .en_i  (en[prd_pkg::GeomBase +: prd_pkg::GeomStg]),
    .cfg_i (cfg_q),
    .sx_i  (s_axis_tdata[15:0]),
    .sy_i  (s_axis_tdata[31:16]),
    .out_o (geom)
  );

  prd_norm u_norm (
    .clk_i (clk_i),
    .en_i  (en[prd_pkg::NormBase +: prd_pkg::NormStg]),
    .in_i  (geom),
    .out_o (norm)
  );

  prd_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en[prd_pkg::SqrtBase +: prd_pkg::SqrtStg]),
    .in_i  (norm),
    .out_o (root)
  );

  prd_div u_div (
    .clk_i   (clk_i),
    .en_i    (en[prd_pkg::DivBase +: prd_pkg::DivStg]),
    .in_i    (root),
    .data_o  (m_axis_tdata),
    .degen_o (degen)
  );

  assign s_axis_tready   = en[0];
  assign m_axis_tvalid   = valid_q[N-1];
  assign m_axis_tuser[0] = degen;

  `PRD_ASSERT_IMP(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
  `PRD_ASSERT_IMP(a_degen_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 48'h0, "degenerate item not zero")
  `PRD_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, valid_q[0], "accepted item lost at entry")

endmodule

`default_nettype wire

// File: sv/prd_geom.sv
// Window mapping, axis products and direction sum with magnitude split.
// Three register stages; depends on prd_pkg.
`default_nettype none

module prd_geom (
  input  wire logic                                  clk_i,
  input  wire logic [prd_pkg::GeomStg-1:0]           en_i,
  input  wire prd_pkg::cfg_t                         cfg_i,
  input  wire logic [prd_pkg::ScrWidth-1:0]          sx_i,
  input  wire logic [prd_pkg::ScrWidth-1:0]          sy_i,
  output prd_pkg::geom_t                             out_o
);

  localparam logic [prd_pkg::WinWidth-1:0] One = prd_pkg::WinWidth'(prd_pkg::WinOne);

  logic [prd_pkg::WinWidth-1:0] wsx, wsy, wex, wey;
  logic signed [prd_pkg::WinWidth:0] dx, dy;
  logic signed [prd_pkg::PxWidth:0] mx, my;
  logic signed [prd_pkg::PxWidth-1:0] px_d, py_d, px_q, py_q;
  logic signed [prd_pkg::ProdWidth-1:0] pu_d [3];
  logic signed [prd_pkg::ProdWidth-1:0] pv_d [3];
  logic signed [prd_pkg::ProdWidth-1:0] pu_q [3];
  logic signed [prd_pkg::ProdWidth-1:0] pv_q [3];
  prd_pkg::geom_t g_d, g_q;

  always_comb begin
    wsx  = (cfg_i.win_sx > One) ? One : cfg_i.win_sx;
    wsy  = (cfg_i.win_sy > One) ? One : cfg_i.win_sy;
    wex  = (cfg_i.win_ex > One) ? One : cfg_i.win_ex;
    wey  = (cfg_i.win_ey > One) ? One : cfg_i.win_ey;
    dx   = $signed({1'b0, wex}) - $signed({1'b0, wsx});
    dy   = $signed({1'b0, wey}) - $signed({1'b0, wsy});
    mx   = $signed({1'b0, sx_i}) * dx;
    my   = $signed({1'b0, sy_i}) * dy;
    px_d = prd_pkg::PxWidth'(mx + $signed({2'b00, wsx, 16'h0000}));
    py_d = prd_pkg::PxWidth'(my + $signed({2'b00, wsy, 16'h0000}));
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pu_d[i] = px_q * prd_pkg::comp(cfg_i.axis_u, i);
      pv_d[i] = py_q * prd_pkg::comp(cfg_i.axis_v, i);
    end
  end

  always_comb begin
    logic signed [prd_pkg::DWidth-1:0] d;
    logic signed [prd_pkg::DWidth-1:0] c;
    logic        [prd_pkg::DWidth-1:0] a;
    d = '0;
    c = '0;
    a = '0;
    for (int i = 0; i < 3; i++) begin
      c = prd_pkg::DWidth'(prd_pkg::comp(cfg_i.corner, i)) <<< 32;
      d = c + prd_pkg::DWidth'(pu_q[i]) + prd_pkg::DWidth'(pv_q[i]);
      a = d[prd_pkg::DWidth-1] ? -d : d;
      g_d.neg[i] = d[prd_pkg::DWidth-1];
      g_d.mag[i] = a[prd_pkg::MagWidth-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      px_q <= px_d;
      py_q <= py_d;
    end
    if (en_i[1]) begin
      pu_q <= pu_d;
      pv_q <= pv_d;
    end
    if (en_i[2]) begin
      g_q <= g_d;
    end
  end

  assign out_o = g_q;

endmodule

`default_nettype wire

// File: sv/prd_norm.sv
// Normalization front end: largest magnitude, shift to fixed bit length,
// squares and squared length. Four register stages; depends on prd_pkg.
`default_nettype none

module prd_norm (
  input  wire logic                        clk_i,
  input  wire logic [prd_pkg::NormStg-1:0] en_i,
  input  wire prd_pkg::geom_t              in_i,
  output prd_pkg::norm_t                   out_o
);

  localparam int NW = $clog2(prd_pkg::MagWidth + 1);

  prd_pkg::geom_t              g_q;
  logic [prd_pkg::MagWidth-1:0] m_d, m_q;
  logic                        zero_q1, zero_q2, zero_q3, zero_q4;
  logic [NW-1:0]               n;
  logic [2:0][prd_pkg::NormBits-1:0] e_d, e_q2, e_q3, e_q4;
  logic [2:0]                  neg_q2, neg_q3, neg_q4;
  logic [prd_pkg::SqWidth-1:0] sq_d [3];
  logic [prd_pkg::SqWidth-1:0] sq_q [3];
  logic [prd_pkg::LenWidth-1:0] len_d, len_q;

  always_comb begin
    m_d = in_i.mag[0];
    if (in_i.mag[1] > m_d) m_d = in_i.mag[1];
    if (in_i.mag[2] > m_d) m_d = in_i.mag[2];
  end

  always_comb begin
    logic [prd_pkg::MagWidth+prd_pkg::NormBits-1:0] t;
    t = '0;
    n = '0;
    for (int b = 0; b < prd_pkg::MagWidth; b++) begin
      if (m_q[b]) n = NW'(b + 1);
    end
    for (int i = 0; i < 3; i++) begin
      t = {g_q.mag[i], {prd_pkg::NormBits{1'b0}}} >> n;
      e_d[i] = t[prd_pkg::NormBits-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = e_q2[i] * e_q2[i];
    end
    len_d = prd_pkg::LenWidth'(sq_q[0]) + prd_pkg::LenWidth'(sq_q[1])
          + prd_pkg::LenWidth'(sq_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      g_q     <= in_i;
      m_q     <= m_d;
      zero_q1 <= (m_d == '0);
    end
    if (en_i[1]) begin
      e_q2    <= e_d;
      neg_q2  <= g_q.neg;
      zero_q2 <= zero_q1;
    end
    if (en_i[2]) begin
      sq_q    <= sq_d;
      e_q3    <= e_q2;
      neg_q3  <= neg_q2;
      zero_q3 <= zero_q2;
    end
    if (en_i[3]) begin
      len_q   <= len_d;
      e_q4    <= e_q3;
      neg_q4  <= neg_q3;
      zero_q4 <= zero_q3;
    end
  end

  assign out_o = '{e: e_q4, neg: neg_q4, zero: zero_q4, len2: len_q};

endmodule

`default_nettype wire

// File: sv/prd_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries the normalized components alongside; depends on prd_pkg.
`default_nettype none

module prd_sqrt (
  input  wire logic                        clk_i,
  input  wire logic [prd_pkg::SqrtStg-1:0] en_i,
  input  wire prd_pkg::norm_t              in_i,
  output prd_pkg::root_t                   out_o
);

  localparam int S = prd_pkg::SqrtStg;

  logic [prd_pkg::LenWidth-1:0]  x_q    [S];
  logic [prd_pkg::RemWidth-1:0]  rem_q  [S];
  logic [prd_pkg::RootWidth-1:0] root_q [S];
  prd_pkg::side_t                side_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic [prd_pkg::LenWidth-1:0]  x_in;
    logic [prd_pkg::RemWidth-1:0]  rem_in, rem_sh, trial;
    logic [prd_pkg::RootWidth-1:0] root_in;
    prd_pkg::side_t                side_in;
    logic                          take;

    if (k == 0) begin : g_first
      assign x_in    = in_i.len2;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = '{e: in_i.e, neg: in_i.neg, zero: in_i.zero};
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in[prd_pkg::RemWidth-3:0], x_in[prd_pkg::LenWidth-1 -: 2]};
    assign trial  = prd_pkg::RemWidth'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        x_q[k]    <= x_in << 2;
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[prd_pkg::RootWidth-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign out_o = '{side: side_q[S-1], r: root_q[S-1]};

endmodule

`default_nettype wire

// File: sv/prd_div.sv
// Rounded division of each component by the length, one quotient bit
// per stage, then saturation, sign and output register; depends on prd_pkg.
`default_nettype none

module prd_div (
  input  wire logic                             clk_i,
  input  wire logic [prd_pkg::DivStg-1:0]       en_i,
  input  wire prd_pkg::root_t                   in_i,
  output logic [3*prd_pkg::OutWidth-1:0]        data_o,
  output logic                                  degen_o
);

  localparam int Q = prd_pkg::QWidth;
  localparam int NumW = prd_pkg::NumWidth;

  logic [2:0][NumW-1:0]           num_q [Q+1];
  logic [2:0][Q-1:0]              quo_q [Q+1];
  logic [prd_pkg::DenWidth-1:0]   den_q [Q+1];
  logic [2:0]                     neg_q [Q+1];
  logic                           zero_q [Q+1];
  logic [3*prd_pkg::OutWidth-1:0] data_d, data_q;
  logic                           degen_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        num_q[0][i] <= NumW'({in_i.side.e[i], {Q{1'b0}}}) + NumW'(in_i.r);
      end
      quo_q[0]  <= '0;
      den_q[0]  <= {in_i.r, 1'b0};
      neg_q[0]  <= in_i.side.neg;
      zero_q[0] <= in_i.side.zero;
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_step
    localparam int B = Q - k;
    logic [NumW:0]        dsh;
    logic [2:0][NumW-1:0] num_d;
    logic [2:0]           bit_d;

    assign dsh = (NumW + 1)'(den_q[k-1]) << B;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        bit_d[i] = ({1'b0, num_q[k-1][i]} >= dsh);
        num_d[i] = bit_d[i] ? NumW'({1'b0, num_q[k-1][i]} - dsh) : num_q[k-1][i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        num_q[k]  <= num_d;
        for (int i = 0; i < 3; i++) begin
          quo_q[k][i] <= {quo_q[k-1][i][Q-2:0], bit_d[i]};
        end
        den_q[k]  <= den_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  always_comb begin
    logic [Q-1:0] q;
    q = '0;
    data_d = '0;
    for (int i = 0; i < 3; i++) begin
      q = quo_q[Q][i];
      if (zero_q[Q]) begin
        data_d[i*prd_pkg::OutWidth +: prd_pkg::OutWidth] = '0;
      end else if (neg_q[Q][i]) begin
        if (q > 16'h8000) q = 16'h8000;
        data_d[i*prd_pkg::OutWidth +: prd_pkg::OutWidth] = -q;
      end else begin
        if (q > 16'h7fff) q = 16'h7fff;
        data_d[i*prd_pkg::OutWidth +: prd_pkg::OutWidth] = q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[Q+1]) begin
      data_q  <= data_d;
      degen_q <= zero_q[Q];
    end
  end

  assign data_o  = data_q;
  assign degen_o = degen_q;

endmodule

`default_nettype wire

// File: sim/ray_direction_checker.sv
// Checker for the pinhole ray direction unit: watches both streams, computes
// the expected unit direction of each accepted sample and compares results.
// Depends on prd_pkg for the register index codes.
module ray_direction_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [62:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] dir_z;
    logic [15:0] dir_y;
    logic [15:0] dir_x;
    logic        degenerate;
  } ray_t;

  logic [62:0] corner_q, axis_u_q, axis_v_q;
  logic [16:0] win_sx_q, win_sy_q, win_ex_q, win_ey_q;
  ray_t expected_rays[$];

  function automatic longint signed component(logic [62:0] v, int i);
    logic signed [20:0] c;
    c = v[i*21 +: 21];
    return longint'(c);
  endfunction

  function automatic longint signed clamp_win(logic [16:0] w);
    return (w > 17'd65536) ? 65536 : longint'(w);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_t predict_ray(logic [15:0] sx, logic [15:0] sy);
    ray_t r;
    longint signed wsx, wsy, wex, wey, px, py, d;
    longint unsigned mag[3], m, len2, root, q;
    bit neg[3];
    int n;
    wsx = clamp_win(win_sx_q);
    wex = clamp_win(win_ex_q);
    wsy = clamp_win(win_sy_q);
    wey = clamp_win(win_ey_q);
    px = wsx * 65536 + longint'(sx) * (wex - wsx);
    py = wsy * 65536 + longint'(sy) * (wey - wsy);
    m = 0;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d = (component(corner_q, i) <<< 32) + px * component(axis_u_q, i)
          + py * component(axis_v_q, i);
      neg[i] = d < 0;
      mag[i] = neg[i] ? -d : d;
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    n = 0;
    while (n < 64 && (m >> n) != 0) n++;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (n > 30) mag[i] >>= (n - 30);
      else mag[i] <<= (30 - n);
      len2 += mag[i] * mag[i];
    end
    root = int_sqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 65536 + root) / (2 * root);
      if (neg[i]) begin
        if (q > 32768) q = 32768;
        q = (65536 - q) & 16'hffff;
      end else if (q > 32767) begin
        q = 32767;
      end
      case (i)
        0: r.dir_x = q[15:0];
        1: r.dir_y = q[15:0];
        default: r.dir_z = q[15:0];
      endcase
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ray_t got, want;
    if (!rst_ni) begin
      corner_q <= '0;
      axis_u_q <= '0;
      axis_v_q <= '0;
      win_sx_q <= '0;
      win_sy_q <= '0;
      win_ex_q <= 17'd65536;
      win_ey_q <= 17'd65536;
      errors_o <= 0;
      pending_o <= 0;
      expected_rays.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_rays.push_back(predict_ray(s_axis_tdata[15:0], s_axis_tdata[31:16]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0]};
        if (expected_rays.size() == 0) begin
          $error("unexpected result %h", got);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_rays.pop_front();
          if (got !== want) begin
            errors_o <= errors_o + 1;
            if (got.dir_x !== want.dir_x)
              $error("dir_x expected %0d got %0d", $signed(want.dir_x), $signed(got.dir_x));
            if (got.dir_y !== want.dir_y)
              $error("dir_y expected %0d got %0d", $signed(want.dir_y), $signed(got.dir_y));
            if (got.dir_z !== want.dir_z)
              $error("dir_z expected %0d got %0d", $signed(want.dir_z), $signed(got.dir_z));
            if (got.degenerate !== want.degenerate)
              $error("degenerate expected %0d got %0d", want.degenerate, got.degenerate);
          end
        end
      end
      pending_o <= expected_rays.size();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          prd_pkg::RegCorner: corner_q <= cfg_wdata_i;
          prd_pkg::RegAxisU:  axis_u_q <= cfg_wdata_i;
          prd_pkg::RegAxisV:  axis_v_q <= cfg_wdata_i;
          prd_pkg::RegWinSx:  win_sx_q <= cfg_wdata_i[16:0];
          prd_pkg::RegWinSy:  win_sy_q <= cfg_wdata_i[16:0];
          prd_pkg::RegWinEx:  win_ex_q <= cfg_wdata_i[16:0];
          prd_pkg::RegWinEy:  win_ey_q <= cfg_wdata_i[16:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: sim/pinhole_ray_direction_unit_test.sv
// Testbench top for the pinhole ray direction unit: clock, reset, register
// setups, sample stimulus with random idling and stalls, and the verdict.
// Depends on prd_pkg, the unit and ray_direction_checker.
module pinhole_ray_direction_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [62:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  int          errors, pending;
  int          send_idle_pct = 0, recv_stall_pct = 0, hold_cycles = 0;

  pinhole_ray_direction_unit dut (.*);
  ray_direction_checker checker_i (.*, .errors_o(errors), .pending_o(pending));

  initial forever #6 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(prd_pkg::reg_idx_e idx, logic [62:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(logic [15:0] sx, logic [15:0] sy);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sy, sx};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] rand_vector(int scale);
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    // Small vectors now and then so that sums cancel to zero more often.
    if (scale == 1) v = v & {3{21'h00000f}} | {3{{21{v[62]}} & 21'h1ffff0}};
    return v;
  endfunction

  task automatic random_setup(int k);
    logic [16:0] w[4];
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(4))
        0: w[i] = 17'd0;
        1: w[i] = 17'd65536;
        2: w[i] = 17'h1ffff;
        default: w[i] = 17'($urandom);
      endcase
    end
    write_reg(prd_pkg::RegCorner, (k % 5 == 0) ? '0 : rand_vector(k % 3));
    write_reg(prd_pkg::RegAxisU, (k % 7 == 0) ? 63'h7fffffffffffffff : rand_vector(k % 3));
    write_reg(prd_pkg::RegAxisV, (k % 7 == 1) ? '0 : rand_vector(k % 3));
    write_reg(prd_pkg::RegWinSx, 63'(w[0]));
    write_reg(prd_pkg::RegWinSy, 63'(w[1]));
    write_reg(prd_pkg::RegWinEx, 63'(w[2]));
    write_reg(prd_pkg::RegWinEy, 63'(w[3]));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Reset settings give the zero direction.
    send_sample(16'h0000, 16'h0000);
    send_sample(16'hffff, 16'hffff);
    drain_pipeline();
    // Corner +z, axes -x and +y; then equal negative corner parts.
    write_reg(prd_pkg::RegCorner, {21'h008000, 21'd0, 21'd0});
    write_reg(prd_pkg::RegAxisU, {21'd0, 21'd0, 21'h100000});
    write_reg(prd_pkg::RegAxisV, {21'd0, 21'h0fffff, 21'd0});
    write_reg(prd_pkg::RegWinSx, 63'd131071);
    write_reg(prd_pkg::RegWinEx, 63'd0);
    write_reg(prd_pkg::RegWinSy, 63'd65536);
    write_reg(prd_pkg::RegWinEy, 63'd65536);
    write_reg(prd_pkg::reg_idx_e'(3'd7), '1);
    for (int i = 0; i < 16; i++) send_sample(edge_value(), edge_value());
    send_sample(16'h5555, 16'haaaa);
    send_sample(16'haaaa, 16'h5555);
    drain_pipeline();
    write_reg(prd_pkg::RegCorner, {3{21'h100000}});
    write_reg(prd_pkg::RegAxisU, {3{21'h0fffff}});
    write_reg(prd_pkg::RegAxisV, '0);
    write_reg(prd_pkg::RegWinSx, 63'd0);
    for (int i = 0; i < 4; i++) send_sample(edge_value(), 16'($urandom));
    drain_pipeline();

    for (int k = 0; k < 35; k++) begin
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_setup(k);
      if (k == 3) hold_cycles = 200;
      for (int i = 0; i < 50; i++)
        send_sample(($urandom_range(5) == 0) ? edge_value() : 16'($urandom),
                    ($urandom_range(5) == 0) ? edge_value() : 16'($urandom));
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/prd_pkg.sv
sv/prd_geom.sv
sv/prd_norm.sv
sv/prd_sqrt.sv
sv/prd_div.sv
sv/pinhole_ray_direction_unit.sv
sim/ray_direction_checker.sv
sim/pinhole_ray_direction_unit_test.sv
